// ===== rtl/ncs_pkg.sv =====
// ----------------------------------------------------------------------------
// ncs_pkg
// shared types and codes of the nand command sequencer
// ----------------------------------------------------------------------------
package ncs_pkg;

  localparam int unsigned PADDR_W = 2;

  // request codes
  localparam logic [2:0] REQ_PROBE    = 3'd0;
  localparam logic [2:0] REQ_IDENTIFY = 3'd1;
  localparam logic [2:0] REQ_ERASE    = 3'd2;
  localparam logic [2:0] REQ_READ     = 3'd3;
  localparam logic [2:0] REQ_PSTART   = 3'd4;
  localparam logic [2:0] REQ_PFINISH  = 3'd5;
  localparam logic [2:0] REQ_STATUS   = 3'd6;

  // job codes passed from front to back
  localparam logic [3:0] OP_PROBE      = 4'd0;
  localparam logic [3:0] OP_IDENTIFY   = 4'd1;
  localparam logic [3:0] OP_ERASE      = 4'd2;
  localparam logic [3:0] OP_READ       = 4'd3;
  localparam logic [3:0] OP_PSTART     = 4'd4;
  localparam logic [3:0] OP_PFINISH    = 4'd5;
  localparam logic [3:0] OP_PROBE_OK   = 4'd6;
  localparam logic [3:0] OP_PROBE_FAIL = 4'd7;
  localparam logic [3:0] OP_WAIT_RPT   = 4'd8;

  // cycle kinds on the result side
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_ADDR   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // status bits
  localparam int unsigned ST_FAIL_BIT   = 0;
  localparam int unsigned ST_READY_BIT  = 6;
  localparam int unsigned ST_UNPROT_BIT = 7;

  localparam logic [7:0] PROBE_LIMIT_RESET = 8'd64;

  typedef struct packed {
    logic [3:0]  op;
    logic [23:0] page;
    logic [15:0] column;
    logic        flag;        // write protect or fail bit for reports
    logic        supported;
    logic [2:0]  size_code;
    logic [6:0]  ppb;
  } job_t;

  typedef struct packed {
    logic [1:0] cycle_kind;
    logic [7:0] bus_byte;
    logic       done_res;
    logic       failed;
    logic       write_protected;
    logic       supported;
    logic [2:0] size_code;
    logic [6:0] pages_per_block;
    logic       last;
  } result_t;

endpackage

// ===== rtl/nand_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// nand_command_sequencer
// turns flash requests and status words into command, address and report words
// ----------------------------------------------------------------------------
// a request's first word reaches the result ports through the job queue slot, written
//   at the push edge, and then the output register, which waits for a free slot or pop
// throughput: one result word per cycle while pop keeps up; a request yields one to
//   seven words, so sustained rate is set by the back end's word count per request
// reset (rst, synchronous): phase idle, retry count 0, retry limit 64, queues empty
module nand_command_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  // request side
  input  logic                        push,
  output logic                        full,
  input  logic [2:0]                  command,
  input  logic [23:0]                 page,
  input  logic [15:0]                 column,
  input  logic [7:0]                  status_byte,
  input  logic [7:0]                  id_maker,
  input  logic [7:0]                  id_device,
  input  logic [7:0]                  id_extra,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ncs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  cycle_kind,
  output logic [7:0]                  bus_byte,
  output logic                        done_res,
  output logic                        failed,
  output logic                        write_protected,
  output logic                        supported,
  output logic [2:0]                  size_code,
  output logic [6:0]                  pages_per_block,
  output logic                        last
);

  logic             accept;
  logic             job_valid;
  ncs_pkg::job_t    new_job;
  ncs_pkg::job_t    head_job;
  logic             q_not_empty;
  logic             job_done;
  logic             out_valid;
  ncs_pkg::result_t out_res;
  logic [7:0]       probe_retry_limit;

  // config register: retry limit at byte address 0
  assign pready = 1'b1;
  assign prdata = (paddr == '0) ? {24'd0, probe_retry_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_retry_limit <= ncs_pkg::PROBE_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == '0) begin
      probe_retry_limit <= pwdata[7:0];
    end
  end

  // a word is taken whenever the job queue has room; words that make no job
  // (idle status, unknown codes) only touch the front's state
  assign accept = push && !full;

  ncs_front u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .command           (command),
    .page              (page),
    .column            (column),
    .status_byte       (status_byte),
    .id_maker          (id_maker),
    .id_device         (id_device),
    .id_extra          (id_extra),
    .probe_retry_limit (probe_retry_limit),
    .job_valid         (job_valid),
    .job               (new_job)
  );

  // short queue decouples decode from bus sequencing
  ncs_job_fifo u_job_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept && job_valid),
    .wr_job    (new_job),
    .rd_en     (job_done),
    .full      (full),
    .not_empty (q_not_empty),
    .rd_job    (head_job)
  );

  // back end emits one word per cycle into the output register while it is empty or popped
  ncs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_ready (q_not_empty),
    .job       (head_job),
    .job_done  (job_done),
    .out_valid (out_valid),
    .out_take  (pop),
    .out_res   (out_res)
  );

  assign empty           = !out_valid;
  assign cycle_kind      = out_res.cycle_kind;
  assign bus_byte        = out_res.bus_byte;
  assign done_res        = out_res.done_res;
  assign failed          = out_res.failed;
  assign write_protected = out_res.write_protected;
  assign supported       = out_res.supported;
  assign size_code       = out_res.size_code;
  assign pages_per_block = out_res.pages_per_block;
  assign last            = out_res.last;

endmodule

// ===== rtl/ncs_front.sv =====
// ----------------------------------------------------------------------------
// ncs_front
// decodes requests and status words into jobs, tracks the wait phase
// ----------------------------------------------------------------------------
module ncs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [2:0]         command,
  input  logic [23:0]        page,
  input  logic [15:0]        column,
  input  logic [7:0]         status_byte,
  input  logic [7:0]         id_maker,
  input  logic [7:0]         id_device,
  input  logic [7:0]         id_extra,
  input  logic [7:0]         probe_retry_limit,
  output logic               job_valid,
  output ncs_pkg::job_t      job
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PROBE = 2'd1;
  localparam logic [1:0] PH_ERASE = 2'd2;
  localparam logic [1:0] PH_PROG  = 2'd3;

  logic [1:0] phase, phase_next;
  logic [7:0] retries_left, retries_left_next;
  logic [10:0] id_info;

  // id table: {supported, size_code, pages per block}
  function automatic logic [10:0] id_decode(input logic [7:0] maker,
                                            input logic [7:0] dev,
                                            input logic [7:0] extra);
    logic [10:0] r;
    r = '0;
    if (maker == 8'h98) begin
      unique case (dev)
        8'h75:   r = {1'b1, 3'd0, 7'd16};
        8'h76:   r = {1'b1, 3'd1, 7'd16};
        8'h79:   r = {1'b1, 3'd2, 7'd0};
        8'hF1:   r = {1'b1, 3'd2, 7'd64};
        8'hDA:   r = {1'b1, 3'd3, 7'd64};
        default: r = '0;
      endcase
    end else if (maker == 8'hEC || maker == 8'hAD || maker == 8'h20) begin
      unique case (dev)
        8'h75:   r = {1'b1, 3'd0, 7'd16};
        8'h76:   r = {1'b1, 3'd1, 7'd16};
        8'h79:   r = {1'b1, 3'd2, 7'd16};
        8'hF1:   r = {1'b1, 3'd2, 7'd64};
        8'h71:   r = {1'b1, 3'd3, 7'd16};
        8'hDA:   r = {1'b1, 3'd3, 7'd64};
        8'hDC:   r = {1'b1, 3'd4, (extra == 8'h15) ? 7'd64 : 7'd16};
        8'hD3:   r = {1'b1, 3'd5, 7'd64};
        8'hD5:   r = {1'b1, 3'd6, 7'd64};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  assign id_info = id_decode(id_maker, id_device, id_extra);

  always_comb begin
    phase_next        = phase;
    retries_left_next = retries_left;
    job_valid         = 1'b0;
    job.op            = ncs_pkg::OP_PROBE;
    job.page          = page;
    job.column        = column;
    job.flag          = 1'b0;
    job.supported     = id_info[10];
    job.size_code     = id_info[9:7];
    job.ppb           = id_info[6:0];
    unique case (command)
      ncs_pkg::REQ_PROBE: begin
        job_valid         = 1'b1;
        job.op            = ncs_pkg::OP_PROBE;
        phase_next        = PH_PROBE;
        retries_left_next = probe_retry_limit;
      end
      ncs_pkg::REQ_IDENTIFY: begin
        job_valid = 1'b1;
        job.op    = ncs_pkg::OP_IDENTIFY;
      end
      ncs_pkg::REQ_ERASE: begin
        job_valid  = 1'b1;
        job.op     = ncs_pkg::OP_ERASE;
        phase_next = PH_ERASE;
      end
      ncs_pkg::REQ_READ: begin
        job_valid  = 1'b1;
        job.op     = ncs_pkg::OP_READ;
        phase_next = PH_IDLE;
      end
      ncs_pkg::REQ_PSTART: begin
        job_valid  = 1'b1;
        job.op     = ncs_pkg::OP_PSTART;
        phase_next = PH_IDLE;
      end
      ncs_pkg::REQ_PFINISH: begin
        job_valid  = 1'b1;
        job.op     = ncs_pkg::OP_PFINISH;
        phase_next = PH_PROG;
      end
      ncs_pkg::REQ_STATUS: begin
        if (phase == PH_PROBE) begin
          job_valid = 1'b1;
          if (status_byte[ncs_pkg::ST_READY_BIT] && !status_byte[ncs_pkg::ST_FAIL_BIT]) begin
            job.op     = ncs_pkg::OP_PROBE_OK;
            job.flag   = ~status_byte[ncs_pkg::ST_UNPROT_BIT];
            phase_next = PH_IDLE;
          end else if (retries_left == 8'd0) begin
            job.op     = ncs_pkg::OP_PROBE_FAIL;
            phase_next = PH_IDLE;
          end else begin
            job.op            = ncs_pkg::OP_PROBE;
            retries_left_next = retries_left - 8'd1;
          end
        end else if (phase == PH_ERASE || phase == PH_PROG) begin
          if (status_byte[ncs_pkg::ST_READY_BIT]) begin
            job_valid  = 1'b1;
            job.op     = ncs_pkg::OP_WAIT_RPT;
            job.flag   = status_byte[ncs_pkg::ST_FAIL_BIT];
            phase_next = PH_IDLE;
          end
        end
      end
      default: begin
        job_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      retries_left <= 8'd0;
    end else if (accept) begin
      phase        <= phase_next;
      retries_left <= retries_left_next;
    end
  end

endmodule

// ===== rtl/ncs_job_fifo.sv =====
// ----------------------------------------------------------------------------
// ncs_job_fifo
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module ncs_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ncs_pkg::job_t wr_job,
  input  logic          rd_en,
  output logic          full,
  output logic          not_empty,
  output ncs_pkg::job_t rd_job
);

  ncs_pkg::job_t slots [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ncs_back.sv =====
// ----------------------------------------------------------------------------
// ncs_back
// steps through a job, one bus word per cycle while the output register is free or popped
// ----------------------------------------------------------------------------
module ncs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_ready,
  input  ncs_pkg::job_t    job,
  output logic             job_done,
  output logic             out_valid,
  input  logic             out_take,
  output ncs_pkg::result_t out_res
);

  logic [2:0]       step;
  logic             advance;
  ncs_pkg::result_t res;

  function automatic ncs_pkg::result_t cmd_word(input logic [7:0] b);
    ncs_pkg::result_t r;
    r            = '0;
    r.cycle_kind = ncs_pkg::KIND_CMD;
    r.bus_byte   = b;
    return r;
  endfunction

  function automatic ncs_pkg::result_t addr_word(input logic [7:0] b);
    ncs_pkg::result_t r;
    r            = '0;
    r.cycle_kind = ncs_pkg::KIND_ADDR;
    r.bus_byte   = b;
    return r;
  endfunction

  function automatic ncs_pkg::result_t report_word(input logic fail, input logic wp);
    ncs_pkg::result_t r;
    r                 = '0;
    r.cycle_kind      = ncs_pkg::KIND_REPORT;
    r.done_res        = 1'b1;
    r.failed          = fail;
    r.write_protected = wp;
    return r;
  endfunction

  // address bytes for the five-byte column+row form
  function automatic logic [7:0] cr_byte(input ncs_pkg::job_t j, input logic [2:0] s);
    logic [7:0] b;
    unique case (s)
      3'd1:    b = j.column[7:0];
      3'd2:    b = j.column[15:8];
      3'd3:    b = j.page[7:0];
      3'd4:    b = j.page[15:8];
      default: b = j.page[23:16];
    endcase
    return b;
  endfunction

  always_comb begin
    res = '0;
    unique case (job.op)
      ncs_pkg::OP_PROBE: begin
        res      = (step == 3'd0) ? cmd_word(8'hFF) : cmd_word(8'h70);
        res.last = (step == 3'd1);
      end
      ncs_pkg::OP_IDENTIFY: begin
        res                 = report_word(~job.supported, 1'b0);
        res.supported       = job.supported;
        res.size_code       = job.size_code;
        res.pages_per_block = job.ppb;
        res.last            = 1'b1;
      end
      ncs_pkg::OP_ERASE: begin
        unique case (step)
          3'd0:    res = cmd_word(8'h60);
          3'd1:    res = addr_word(job.page[7:0]);
          3'd2:    res = addr_word(job.page[15:8]);
          3'd3:    res = addr_word(job.page[23:16]);
          3'd4:    res = cmd_word(8'hD0);
          default: res = cmd_word(8'h70);
        endcase
        res.last = (step == 3'd5);
      end
      ncs_pkg::OP_READ: begin
        if (step == 3'd0) begin
          res = cmd_word(8'h00);
        end else if (step == 3'd6) begin
          res = cmd_word(8'h30);
        end else begin
          res = addr_word(cr_byte(job, step));
        end
        res.last = (step == 3'd6);
      end
      ncs_pkg::OP_PSTART: begin
        res      = (step == 3'd0) ? cmd_word(8'h80) : addr_word(cr_byte(job, step));
        res.last = (step == 3'd5);
      end
      ncs_pkg::OP_PFINISH: begin
        res      = (step == 3'd0) ? cmd_word(8'h10) : cmd_word(8'h70);
        res.last = (step == 3'd1);
      end
      ncs_pkg::OP_PROBE_OK: begin
        res      = (step == 3'd0) ? cmd_word(8'h90) : report_word(1'b0, job.flag);
        res.last = (step == 3'd1);
      end
      ncs_pkg::OP_PROBE_FAIL: begin
        res      = (step == 3'd0) ? cmd_word(8'hFF) : report_word(1'b1, 1'b0);
        res.last = (step == 3'd1);
      end
      ncs_pkg::OP_WAIT_RPT: begin
        res      = report_word(job.flag, 1'b0);
        res.last = 1'b1;
      end
      default: begin
        res      = '0;
        res.last = 1'b1;
      end
    endcase
  end

  assign advance  = job_ready && (!out_valid || out_take);
  assign job_done = advance && res.last;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 3'd0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        step      <= res.last ? 3'd0 : step + 3'd1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
